// ===== src/srv_pkg.sv =====
package srv_pkg;

   localparam int COMP_W = 16;
   localparam int COS_W = 19;
   localparam int SQRT_BITS = 29;
   localparam int REM_W = 59;
   localparam int FRAC = 14;

   typedef struct packed {
      logic signed [COMP_W-1:0] inc_x;
      logic signed [COMP_W-1:0] inc_y;
      logic signed [COMP_W-1:0] inc_z;
      logic signed [COMP_W-1:0] norm_x;
      logic signed [COMP_W-1:0] norm_y;
      logic signed [COMP_W-1:0] norm_z;
      logic [COMP_W-1:0]        rel_index;
   } req_type;

   typedef struct packed {
      logic signed [COMP_W-1:0] out_x;
      logic signed [COMP_W-1:0] out_y;
      logic signed [COMP_W-1:0] out_z;
      logic                     valid_res;
   } rsp_type;

   typedef struct packed {
      req_type                 req;
      logic signed [COS_W-1:0] cos_i;
   } carry_type;

   function automatic logic signed [COMP_W-1:0] sat16(input logic signed [25:0] v);
      logic signed [COMP_W-1:0] r;
      if (v > 26'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -26'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

// ===== src/snell_refraction_vector_top.sv =====
// Refraction direction by Snell's law, one request per cycle with no gaps while busy is low. Each request
// gives incident direction and normal (signed Q1.14) and eta (unsigned Q2.14); exactly
// one response follows each request that is taken, in request order, on
// rsp_data marked by a single-cycle rsp_strobe. The pipeline is the square root
// of 1 - sin2_t, which resolves one result bit per stage over 29 stages, plus six
// stages in front (products, cos_i, cos squared, sin2_i, sin2_t and 1 - sin2_t) and four
// behind (scaling of n and wi, rounding and saturation). busy is high only during
// reset; the receiver cannot stall and none is needed. On total internal reflection
// the direction is zero and valid_res is low.
module snell_refraction_vector_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  srv_pkg::req_type req_data,
   output logic             rsp_strobe,
   output srv_pkg::rsp_type rsp_data
);

   localparam int NB = srv_pkg::SQRT_BITS;
   localparam int LATENCY = 5 + (NB + 1) + 4;

   logic accept;
   assign busy = reset;
   assign accept = start && !busy;

   // stage 1: products
   logic                     s1_vld_ff;
   logic signed [31:0]       s1_prod_ff [0:2];
   logic signed [31:0]       s1_prod_in [0:2];
   logic [31:0]              s1_eta2_ff, s1_eta2_in;
   srv_pkg::carry_type       s1_carry_ff;

   always_comb begin
      s1_prod_in[0] = req_data.inc_x * req_data.norm_x;
      s1_prod_in[1] = req_data.inc_y * req_data.norm_y;
      s1_prod_in[2] = req_data.inc_z * req_data.norm_z;
      s1_eta2_in = 32'(req_data.rel_index) * 32'(req_data.rel_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      s1_prod_ff <= s1_prod_in;
      s1_eta2_ff <= s1_eta2_in;
      s1_carry_ff.req <= req_data;
      s1_carry_ff.cos_i <= '0;
   end

   // stage 2: cos_i, round half up
   logic                             s2_vld_ff;
   logic signed [32:0]               s2_dot_in;
   logic [31:0]                      s2_eta2_ff;
   srv_pkg::carry_type               s2_carry_ff, s2_carry_in;

   always_comb begin
      s2_dot_in = 33'(s1_prod_ff[0]) + 33'(s1_prod_ff[1]) + 33'(s1_prod_ff[2])
                + 33'sd8192;
      s2_carry_in = s1_carry_ff;
      s2_carry_in.cos_i = s2_dot_in[32:srv_pkg::FRAC];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
      s2_carry_ff <= s2_carry_in;
      s2_eta2_ff <= s1_eta2_ff;
   end

   // stage 3: cos_i squared
   logic                s3_vld_ff;
   logic signed [37:0]  s3_cossq_ff, s3_cossq_in;
   logic [31:0]         s3_eta2_ff;
   srv_pkg::carry_type  s3_carry_ff;

   assign s3_cossq_in = 38'(s2_carry_ff.cos_i) * 38'(s2_carry_ff.cos_i);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s2_vld_ff;
      end
      s3_cossq_ff <= s3_cossq_in;
      s3_eta2_ff <= s2_eta2_ff;
      s3_carry_ff <= s2_carry_ff;
   end

   // stage 4: sin2_i clamped at zero
   logic                s4_vld_ff;
   logic signed [38:0]  s4_diff;
   logic [28:0]         s4_sin2_ff, s4_sin2_in;
   logic [31:0]         s4_eta2_ff;
   srv_pkg::carry_type  s4_carry_ff;

   always_comb begin
      s4_diff = (39'sd1 <<< 28) - 39'(s3_cossq_ff);
      s4_sin2_in = s4_diff[38] ? 29'd0 : s4_diff[28:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else begin
         s4_vld_ff <= s3_vld_ff;
      end
      s4_sin2_ff <= s4_sin2_in;
      s4_eta2_ff <= s3_eta2_ff;
      s4_carry_ff <= s3_carry_ff;
   end

   // stage 5: sin2_t in Q56
   logic                s5_vld_ff;
   logic [60:0]         s5_sin2t_ff, s5_sin2t_in;
   srv_pkg::carry_type  s5_carry_ff;

   assign s5_sin2t_in = 61'(s4_eta2_ff) * 61'(s4_sin2_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else begin
         s5_vld_ff <= s4_vld_ff;
      end
      s5_sin2t_ff <= s5_sin2t_in;
      s5_carry_ff <= s4_carry_ff;
   end

   // square root pipeline; entry 0 holds 1 - sin2_t and the TIR flag
   logic                          sq_vld_ff   [0:NB];
   logic                          sq_tir_ff   [0:NB];
   logic [srv_pkg::REM_W-1:0]     sq_rem_ff   [0:NB];
   logic [NB-1:0]                 sq_root_ff  [0:NB];
   srv_pkg::carry_type            sq_carry_ff [0:NB];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff[0] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s5_vld_ff;
      end
      sq_tir_ff[0] <= |s5_sin2t_ff[60:56];
      sq_rem_ff[0] <= (srv_pkg::REM_W'(1) << 56) - srv_pkg::REM_W'(s5_sin2t_ff[55:0]);
      sq_root_ff[0] <= '0;
      sq_carry_ff[0] <= s5_carry_ff;
   end

   for (genvar s = 0; s < NB; s++) begin : g_sqrt
      localparam int B = NB - 1 - s;
      logic [srv_pkg::REM_W-1:0] trial;
      logic [srv_pkg::REM_W-1:0] rem_in;
      logic [NB-1:0]             root_in;

      always_comb begin
         trial = (srv_pkg::REM_W'(sq_root_ff[s]) << (B + 1))
               | (srv_pkg::REM_W'(1) << (2 * B));
         if (sq_rem_ff[s] >= trial) begin
            rem_in = sq_rem_ff[s] - trial;
            root_in = sq_root_ff[s] | (NB'(1) << B);
         end else begin
            rem_in = sq_rem_ff[s];
            root_in = sq_root_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[s+1] <= 1'b0;
         end else begin
            sq_vld_ff[s+1] <= sq_vld_ff[s];
         end
         sq_tir_ff[s+1] <= sq_tir_ff[s];
         sq_rem_ff[s+1] <= rem_in;
         sq_root_ff[s+1] <= root_in;
         sq_carry_ff[s+1] <= sq_carry_ff[s];
      end
   end

   // stage A: eta*cos_i and eta*wi
   srv_pkg::req_type    sq_req;
   logic signed [16:0]  sq_eta;
   logic                a_vld_ff, a_tir_ff;
   logic signed [35:0]  a_ec_ff, a_ec_in;
   logic signed [32:0]  a_ew_ff [0:2];
   logic signed [32:0]  a_ew_in [0:2];
   logic signed [15:0]  a_n_ff  [0:2];
   logic [NB-1:0]       a_cost_ff;

   always_comb begin
      sq_req = sq_carry_ff[NB].req;
      sq_eta = $signed({1'b0, sq_req.rel_index});
      a_ec_in = 36'(sq_eta) * 36'(sq_carry_ff[NB].cos_i);
      a_ew_in[0] = 33'(sq_eta) * 33'(sq_req.inc_x);
      a_ew_in[1] = 33'(sq_eta) * 33'(sq_req.inc_y);
      a_ew_in[2] = 33'(sq_eta) * 33'(sq_req.inc_z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= sq_vld_ff[NB];
      end
      a_tir_ff <= sq_tir_ff[NB];
      a_ec_ff <= a_ec_in;
      a_ew_ff <= a_ew_in;
      a_n_ff[0] <= sq_req.norm_x;
      a_n_ff[1] <= sq_req.norm_y;
      a_n_ff[2] <= sq_req.norm_z;
      a_cost_ff <= sq_root_ff[NB];
   end

   // stage B: k = eta*cos_i - cos_t
   logic                b_vld_ff, b_tir_ff;
   logic signed [36:0]  b_k_ff, b_k_in;
   logic signed [32:0]  b_ew_ff [0:2];
   logic signed [15:0]  b_n_ff  [0:2];

   assign b_k_in = 37'(a_ec_ff) - $signed({8'd0, a_cost_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else begin
         b_vld_ff <= a_vld_ff;
      end
      b_tir_ff <= a_tir_ff;
      b_k_ff <= b_k_in;
      b_ew_ff <= a_ew_ff;
      b_n_ff <= a_n_ff;
   end

   // stage C: k*n
   logic                c_vld_ff, c_tir_ff;
   logic signed [52:0]  c_kn_ff [0:2];
   logic signed [52:0]  c_kn_in [0:2];
   logic signed [32:0]  c_ew_ff [0:2];

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         c_kn_in[j] = 53'(b_k_ff) * 53'(b_n_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else begin
         c_vld_ff <= b_vld_ff;
      end
      c_tir_ff <= b_tir_ff;
      c_kn_ff <= c_kn_in;
      c_ew_ff <= b_ew_ff;
   end

   // stage D: subtract, round to Q14, saturate
   logic signed [53:0]  d_acc [0:2];
   logic signed [15:0]  d_out [0:2];
   logic                rsp_strobe_ff;
   srv_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         d_acc[j] = 54'(c_kn_ff[j]) - (54'(c_ew_ff[j]) <<< srv_pkg::FRAC)
                  + (54'sd1 <<< 27);
         d_out[j] = c_tir_ff ? 16'sd0 : srv_pkg::sat16(d_acc[j][53:28]);
      end
      rsp_data_in.out_x = d_out[0];
      rsp_data_in.out_y = d_out[1];
      rsp_data_in.out_z = d_out[2];
      rsp_data_in.valid_res = !c_tir_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= c_vld_ff;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_data_ff;

   a_latency_fwd: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("request did not produce a response at the pipeline depth");

   a_latency_back: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   a_tir_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.valid_res) |->
         (rsp_data.out_x == 16'sd0 && rsp_data.out_y == 16'sd0
          && rsp_data.out_z == 16'sd0))
      else $error("total internal reflection response carries a direction");

   a_sqrt_tir: assert property (@(posedge clock) disable iff (reset)
      (sq_vld_ff[NB] && !sq_tir_ff[NB]) |-> (sq_root_ff[NB] != '0 || sq_rem_ff[NB] == '0))
      else $error("square root stage lost its operand");

endmodule
